[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the sixel encoder blocks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define SXE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define SXE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/sxe_pkg.sv]
// ----------------------------------------------------------------------------
// sxe_pkg
// types, byte codes and helpers shared by the sixel stream encoder
// ----------------------------------------------------------------------------
package sxe_pkg;

  // default frame size limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // depth of the queue between classifier and byte sequencer
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_CHANNEL_MODE = 2'd2;

  localparam int CFG_SIZE_W = 13;
  localparam int CFG_DATA_W = 13;

  // channel modes
  localparam logic [1:0] MODE_FULL  = 2'd0;
  localparam logic [1:0] MODE_RED   = 2'd1;
  localparam logic [1:0] MODE_GREEN = 2'd2;
  localparam logic [1:0] MODE_BLUE  = 2'd3;

  // channel positions in a word
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int NUM_CH   = 3;

  // band handling
  localparam logic [2:0] PHASE_LAST = 3'd5;

  // stream characters
  localparam logic [7:0] CHAR_ESC    = 8'h1B;
  localparam logic [7:0] CHAR_P      = 8'h50;
  localparam logic [7:0] CHAR_Q      = 8'h71;
  localparam logic [7:0] CHAR_HASH   = 8'h23;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_TWO    = 8'h32;
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] SIXEL_BIAS  = 8'd63;

  // percentage scale
  localparam int PCT_FULL = 100;
  localparam logic [6:0] PCT_MAX = 7'd100;

  // byte slots of one pixel, in stream order
  typedef enum logic [4:0] {
    SLOT_ESC_OPEN,
    SLOT_P,
    SLOT_Q,
    SLOT_HASH,
    SLOT_REG0,
    SLOT_SEMI_A,
    SLOT_TWO,
    SLOT_SEMI_B,
    SLOT_RED_H,
    SLOT_RED_T,
    SLOT_RED_O,
    SLOT_SEMI_C,
    SLOT_GRN_H,
    SLOT_GRN_T,
    SLOT_GRN_O,
    SLOT_SEMI_D,
    SLOT_BLU_H,
    SLOT_BLU_T,
    SLOT_BLU_O,
    SLOT_SIXEL,
    SLOT_ROW_END,
    SLOT_ESC_CLOSE,
    SLOT_BSLASH,
    SLOT_NEWLINE
  } slot_e;

  localparam int NUM_SLOTS = 24;

  // input word
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } sxe_pixel_t;

  // output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } sxe_out_t;

  // classified pixel between front and back
  typedef struct packed {
    logic [NUM_SLOTS-1:0]  mask;
    logic [NUM_CH-1:0][6:0] pct;
    logic [2:0]            phase;
    logic                  band_end;
  } sxe_desc_t;

  // c * 100 / 255 rounded down, via reciprocal of 255
  function automatic logic [6:0] scale_pct(input logic [7:0] c);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = 16'(c) * 16'(PCT_FULL);
    sum  = 17'(prod) + 17'(prod >> 8) + 17'd1;
    return sum[14:8];
  endfunction

endpackage

[sv/sxe_front.sv]
// ----------------------------------------------------------------------------
// sxe_front
// accepts pixels, holds configuration and frame position, classifies each
// pixel into a slot mask and scaled channels for the byte sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sxe_front #(
  parameter int MAX_WIDTH  = sxe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sxe_pkg::MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [sxe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sxe_pkg::sxe_pixel_t   in_data_i,
  input  logic                  full_i,
  output logic                  push_o,
  output sxe_pkg::sxe_desc_t    push_data_o
);

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCMP = ((CW > sxe_pkg::CFG_SIZE_W) ? CW : sxe_pkg::CFG_SIZE_W) + 1;
  localparam int HCMP = ((RW > sxe_pkg::CFG_SIZE_W) ? RW : sxe_pkg::CFG_SIZE_W) + 1;

  logic [sxe_pkg::CFG_SIZE_W-1:0] width_q, height_q;
  logic [1:0]                     mode_q;
  logic [CW-1:0]                  col_q, col_d;
  logic [RW-1:0]                  row_q, row_d;
  logic [2:0]                     phase_q, phase_d;

  logic            accept;
  logic [WCMP-1:0] w_eff, w_raw;
  logic [HCMP-1:0] h_eff, h_raw;
  logic            header, col_end, row_last, band_end;
  logic [7:0]      r_sel, g_sel, b_sel;
  sxe_pkg::sxe_desc_t desc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sxe_pkg::CFG_SIZE_W'(1);
      height_q <= sxe_pkg::CFG_SIZE_W'(1);
      mode_q   <= sxe_pkg::MODE_FULL;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sxe_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[sxe_pkg::CFG_SIZE_W-1:0];
        sxe_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[sxe_pkg::CFG_SIZE_W-1:0];
        sxe_pkg::CFG_CHANNEL_MODE: mode_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // clamp the frame size to one and the maximum
  always_comb begin
    w_raw = WCMP'(width_q);
    h_raw = HCMP'(height_q);
    if (w_raw == '0) begin
      w_eff = WCMP'(1);
    end else if (w_raw > WCMP'(MAX_WIDTH)) begin
      w_eff = WCMP'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = HCMP'(1);
    end else if (h_raw > HCMP'(MAX_HEIGHT)) begin
      h_eff = HCMP'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  // frame position
  assign header   = (col_q == '0) && (row_q == '0);
  assign col_end  = (WCMP'(col_q) + WCMP'(1)) >= w_eff;
  assign row_last = (HCMP'(row_q) + HCMP'(1)) >= h_eff;
  assign band_end = (phase_q == sxe_pkg::PHASE_LAST);

  // channel selection
  always_comb begin
    r_sel = in_data_i.red;
    g_sel = in_data_i.green;
    b_sel = in_data_i.blue;
    unique case (mode_q)
      sxe_pkg::MODE_RED: begin
        g_sel = '0;
        b_sel = '0;
      end
      sxe_pkg::MODE_GREEN: begin
        r_sel = '0;
        b_sel = '0;
      end
      sxe_pkg::MODE_BLUE: begin
        r_sel = '0;
        g_sel = '0;
      end
      default: ;
    endcase
  end

  // classification into slots
  always_comb begin
    desc = '0;
    desc.pct[sxe_pkg::CH_RED]   = sxe_pkg::scale_pct(r_sel);
    desc.pct[sxe_pkg::CH_GREEN] = sxe_pkg::scale_pct(g_sel);
    desc.pct[sxe_pkg::CH_BLUE]  = sxe_pkg::scale_pct(b_sel);
    desc.phase    = phase_q;
    desc.band_end = band_end;
    desc.mask[sxe_pkg::SLOT_ESC_OPEN] = header;
    desc.mask[sxe_pkg::SLOT_P]        = header;
    desc.mask[sxe_pkg::SLOT_Q]        = header;
    desc.mask[sxe_pkg::SLOT_HASH]     = 1'b1;
    desc.mask[sxe_pkg::SLOT_REG0]     = 1'b1;
    desc.mask[sxe_pkg::SLOT_SEMI_A]   = 1'b1;
    desc.mask[sxe_pkg::SLOT_TWO]      = 1'b1;
    desc.mask[sxe_pkg::SLOT_SEMI_B]   = 1'b1;
    desc.mask[sxe_pkg::SLOT_RED_H]    = desc.pct[sxe_pkg::CH_RED] >= 7'd100;
    desc.mask[sxe_pkg::SLOT_RED_T]    = desc.pct[sxe_pkg::CH_RED] >= 7'd10;
    desc.mask[sxe_pkg::SLOT_RED_O]    = 1'b1;
    desc.mask[sxe_pkg::SLOT_SEMI_C]   = 1'b1;
    desc.mask[sxe_pkg::SLOT_GRN_H]    = desc.pct[sxe_pkg::CH_GREEN] >= 7'd100;
    desc.mask[sxe_pkg::SLOT_GRN_T]    = desc.pct[sxe_pkg::CH_GREEN] >= 7'd10;
    desc.mask[sxe_pkg::SLOT_GRN_O]    = 1'b1;
    desc.mask[sxe_pkg::SLOT_SEMI_D]   = 1'b1;
    desc.mask[sxe_pkg::SLOT_BLU_H]    = desc.pct[sxe_pkg::CH_BLUE] >= 7'd100;
    desc.mask[sxe_pkg::SLOT_BLU_T]    = desc.pct[sxe_pkg::CH_BLUE] >= 7'd10;
    desc.mask[sxe_pkg::SLOT_BLU_O]    = 1'b1;
    desc.mask[sxe_pkg::SLOT_SIXEL]    = 1'b1;
    desc.mask[sxe_pkg::SLOT_ROW_END]  = col_end;
    desc.mask[sxe_pkg::SLOT_ESC_CLOSE] = col_end && row_last;
    desc.mask[sxe_pkg::SLOT_BSLASH]   = col_end && row_last;
    desc.mask[sxe_pkg::SLOT_NEWLINE]  = col_end && row_last;
  end

  assign accept      = in_valid_i && !full_i;
  assign in_stall_o  = full_i;
  assign push_o      = accept;
  assign push_data_o = desc;

  // position update per accepted pixel
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    phase_d = phase_q;
    if (accept) begin
      if (col_end) begin
        col_d = '0;
        if (row_last) begin
          row_d   = '0;
          phase_d = '0;
        end else begin
          row_d   = row_q + RW'(1);
          phase_d = band_end ? 3'd0 : phase_q + 3'd1;
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      phase_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      phase_q <= phase_d;
    end
  end

  // position never leaves the largest frame
  `SXE_ASSERT(a_pos_range, (col_q <= CW'(MAX_WIDTH - 1)) && (row_q <= RW'(MAX_HEIGHT - 1)), "frame position out of range")
  `SXE_ASSERT(a_phase_range, phase_q <= sxe_pkg::PHASE_LAST, "band phase out of range")

endmodule

[sv/sxe_queue.sv]
// ----------------------------------------------------------------------------
// sxe_queue
// short first-in first-out queue of classified pixels
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sxe_queue #(
  parameter int DEPTH = sxe_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sxe_pkg::sxe_desc_t push_data_i,
  output logic               full_o,
  output logic               valid_o,
  output sxe_pkg::sxe_desc_t head_o,
  input  logic               pop_i
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  sxe_pkg::sxe_desc_t mem_q [DEPTH];
  logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]      count_q;

  assign full_o  = (count_q == NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + NW'(1);
        2'b01:   count_q <= count_q - NW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `SXE_ASSERT(a_no_overflow, full_o |-> !push_i, "word pushed into full queue")
  `SXE_ASSERT(a_no_underflow, !valid_o |-> !pop_i, "word popped from empty queue")

endmodule

[sv/sxe_back.sv]
// ----------------------------------------------------------------------------
// sxe_back
// byte sequencer: walks the slot mask of one pixel and sends one byte of
// the sixel stream per cycle, unless stalled, through an output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sxe_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  sxe_pkg::sxe_desc_t q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sxe_pkg::sxe_out_t  out_data_o
);

  logic                            cur_valid_q, cur_valid_d;
  logic [sxe_pkg::NUM_SLOTS-1:0]   cur_mask_q, cur_mask_d, rem_mask;
  logic [sxe_pkg::NUM_CH-1:0][6:0] pct_q;
  logic [sxe_pkg::NUM_CH-1:0][3:0] tens_q;
  logic [2:0]                      phase_q;
  logic                            band_end_q;
  logic                            out_valid_q;
  sxe_pkg::sxe_out_t               out_q;

  logic        emit_en, done, pop;
  logic [4:0]  slot_idx;
  logic [7:0]  byte_sel;
  logic [14:0] tens_prod [sxe_pkg::NUM_CH];

  // digit characters of a percentage, hundreds flagged by the value itself
  function automatic logic [7:0] tens_char(input logic [6:0] pct, input logic [3:0] tens);
    return (pct == sxe_pkg::PCT_MAX) ? sxe_pkg::CHAR_ZERO
                                     : sxe_pkg::CHAR_ZERO + {4'd0, tens};
  endfunction

  function automatic logic [7:0] ones_char(input logic [6:0] pct, input logic [3:0] tens);
    logic [6:0] diff;
    diff = pct - (7'(tens) * 7'd10);
    return (pct == sxe_pkg::PCT_MAX) ? sxe_pkg::CHAR_ZERO
                                     : sxe_pkg::CHAR_ZERO + {4'd0, diff[3:0]};
  endfunction

  // lowest pending slot
  always_comb begin
    slot_idx = '0;
    for (int i = sxe_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (cur_mask_q[i]) begin
        slot_idx = 5'(i);
      end
    end
  end

  // byte for the current slot
  always_comb begin
    unique case (sxe_pkg::slot_e'(slot_idx))
      sxe_pkg::SLOT_ESC_OPEN:  byte_sel = sxe_pkg::CHAR_ESC;
      sxe_pkg::SLOT_P:         byte_sel = sxe_pkg::CHAR_P;
      sxe_pkg::SLOT_Q:         byte_sel = sxe_pkg::CHAR_Q;
      sxe_pkg::SLOT_HASH:      byte_sel = sxe_pkg::CHAR_HASH;
      sxe_pkg::SLOT_REG0:      byte_sel = sxe_pkg::CHAR_ZERO;
      sxe_pkg::SLOT_TWO:       byte_sel = sxe_pkg::CHAR_TWO;
      sxe_pkg::SLOT_SEMI_A,
      sxe_pkg::SLOT_SEMI_B,
      sxe_pkg::SLOT_SEMI_C,
      sxe_pkg::SLOT_SEMI_D:    byte_sel = sxe_pkg::CHAR_SEMI;
      sxe_pkg::SLOT_RED_H,
      sxe_pkg::SLOT_GRN_H,
      sxe_pkg::SLOT_BLU_H:     byte_sel = sxe_pkg::CHAR_ZERO + 8'd1;
      sxe_pkg::SLOT_RED_T:     byte_sel = tens_char(pct_q[sxe_pkg::CH_RED],
                                                    tens_q[sxe_pkg::CH_RED]);
      sxe_pkg::SLOT_RED_O:     byte_sel = ones_char(pct_q[sxe_pkg::CH_RED],
                                                    tens_q[sxe_pkg::CH_RED]);
      sxe_pkg::SLOT_GRN_T:     byte_sel = tens_char(pct_q[sxe_pkg::CH_GREEN],
                                                    tens_q[sxe_pkg::CH_GREEN]);
      sxe_pkg::SLOT_GRN_O:     byte_sel = ones_char(pct_q[sxe_pkg::CH_GREEN],
                                                    tens_q[sxe_pkg::CH_GREEN]);
      sxe_pkg::SLOT_BLU_T:     byte_sel = tens_char(pct_q[sxe_pkg::CH_BLUE],
                                                    tens_q[sxe_pkg::CH_BLUE]);
      sxe_pkg::SLOT_BLU_O:     byte_sel = ones_char(pct_q[sxe_pkg::CH_BLUE],
                                                    tens_q[sxe_pkg::CH_BLUE]);
      sxe_pkg::SLOT_SIXEL:     byte_sel = sxe_pkg::SIXEL_BIAS + (8'd1 << phase_q);
      sxe_pkg::SLOT_ROW_END:   byte_sel = band_end_q ? sxe_pkg::CHAR_MINUS
                                                     : sxe_pkg::CHAR_DOLLAR;
      sxe_pkg::SLOT_ESC_CLOSE: byte_sel = sxe_pkg::CHAR_ESC;
      sxe_pkg::SLOT_BSLASH:    byte_sel = sxe_pkg::CHAR_BSLASH;
      sxe_pkg::SLOT_NEWLINE:   byte_sel = sxe_pkg::CHAR_NL;
      default:                 byte_sel = sxe_pkg::CHAR_ZERO;
    endcase
  end

  // sequencing control
  assign rem_mask = cur_mask_q & (cur_mask_q - sxe_pkg::NUM_SLOTS'(1));
  assign emit_en  = cur_valid_q && (!out_valid_q || !out_stall_i);
  assign done     = emit_en && (rem_mask == '0);
  assign pop      = q_valid_i && (!cur_valid_q || done);
  assign q_pop_o  = pop;

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_mask_d  = cur_mask_q;
    if (pop) begin
      cur_valid_d = 1'b1;
      cur_mask_d  = q_head_i.mask;
    end else if (emit_en) begin
      cur_valid_d = !done;
      cur_mask_d  = rem_mask;
    end
  end

  // tens digit by reciprocal of ten, exact for every 7-bit percentage
  always_comb begin
    for (int c = 0; c < sxe_pkg::NUM_CH; c++) begin
      tens_prod[c] = 15'(q_head_i.pct[c]) * 15'd205;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cur_mask_q  <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      cur_mask_q  <= cur_mask_d;
    end
  end

  // pixel payload of the word being sent
  always_ff @(posedge clk_i) begin
    if (pop) begin
      for (int c = 0; c < sxe_pkg::NUM_CH; c++) begin
        pct_q[c]  <= q_head_i.pct[c];
        tens_q[c] <= tens_prod[c][14:11];
      end
      phase_q    <= q_head_i.phase;
      band_end_q <= q_head_i.band_end;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_en) begin
      out_q.out_byte    <= byte_sel;
      out_q.last_of_run <= (rem_mask == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SXE_ASSERT(a_busy_has_slots, cur_valid_q |-> (cur_mask_q != '0), "active pixel without pending bytes")
  `SXE_ASSERT(a_head_has_sixel, q_valid_i |-> q_head_i.mask[sxe_pkg::SLOT_SIXEL], "queued pixel without sixel byte")

endmodule

[sv/sixel_pixel_stream_encoder_top.sv]
// ----------------------------------------------------------------------------
// sixel_pixel_stream_encoder_top
// sixel byte stream encoder for raster-order pixels
// ----------------------------------------------------------------------------
// Each pixel yields 11 to 24 output words, one byte per cycle unless the
// output stalls: 11 to 17 for the colour definition and sixel byte, 3 more
// for the frame header, 1 for the row end and 3 for the frame trailer. The
// byte sequencer sends one word per cycle unless stalled, so the output channel
// sets the pixel rate; the next pixel is classified and queued while the
// current one is still being sent; no gap lies between the bytes of two pixels.
// Frame size and channel mode are written through the configuration port
// by the user only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sixel_pixel_stream_encoder_top #(
  parameter int MAX_WIDTH  = sxe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sxe_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [sxe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sxe_pkg::sxe_pixel_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sxe_pkg::sxe_out_t              out_data_o
);

  logic               push, full, q_valid, q_pop;
  sxe_pkg::sxe_desc_t push_data, q_head;

  // classifier
  sxe_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decoupling queue
  sxe_queue #(
    .DEPTH (sxe_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .pop_i       (q_pop)
  );

  // byte sequencer
  sxe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the sixel pixel stream encoder: a queue-fed driver
// offers pixel words, a monitor checks every output word against a predicted
// byte stream, with random idling on both sides and settings changed between
// phases
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int     LONG_HOLD   = 300;
  localparam longint TIMEOUT_NS  = 64'd20_000_000;

  // clock, reset and block inputs, all known from time zero
  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we      = 1'b0;
  logic [1:0]                     cfg_index   = sxe_pkg::CFG_IMAGE_WIDTH;
  logic [sxe_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
  logic                           in_valid_q  = 1'b0;
  sxe_pkg::sxe_pixel_t            in_data_q   = '0;
  logic                           out_stall_q = 1'b0;
  logic                           in_stall_o;
  logic                           out_valid_o;
  sxe_pkg::sxe_out_t              out_data_o;

  // settings as the block holds them
  logic [sxe_pkg::CFG_SIZE_W-1:0] width_reg  = 13'd1;
  logic [sxe_pkg::CFG_SIZE_W-1:0] height_reg = 13'd1;
  logic [1:0]                     mode_reg   = sxe_pkg::MODE_FULL;

  // predicted position in the frame
  logic [11:0] column_pos = '0;
  logic [11:0] row_pos    = '0;
  logic [2:0]  band_pos   = '0;

  sxe_pkg::sxe_pixel_t pending_pixels [$];
  sxe_pkg::sxe_out_t   expected_bytes [$];
  sxe_pkg::sxe_out_t   want;

  // run control
  logic quiet    = 1'b0;
  logic hold_arm = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;
  int   in_gap    = 0;
  int   out_burst = 0;

  int error_count     = 0;
  int pixels_accepted = 0;
  int bytes_checked   = 0;
  int frames_closed   = 0;
  int row_ends        = 0;
  int random_items    = 0;
  int burst_len       = 0;

  sixel_pixel_stream_encoder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid_q),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_q),
    .out_data_o  (out_data_o)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
  endfunction

  // byte stream of one pixel, appended to the expected words
  task automatic predict_pixel(input sxe_pkg::sxe_pixel_t px);
    int unsigned       w;
    int unsigned       h;
    int unsigned       pct;
    logic [7:0]        level [sxe_pkg::NUM_CH];
    logic [7:0]        run_bytes [$];
    sxe_pkg::sxe_out_t item_word;
    w = (width_reg == 0) ? 1 :
        (width_reg > sxe_pkg::MAX_WIDTH_DEF) ? sxe_pkg::MAX_WIDTH_DEF : width_reg;
    h = (height_reg == 0) ? 1 :
        (height_reg > sxe_pkg::MAX_HEIGHT_DEF) ? sxe_pkg::MAX_HEIGHT_DEF : height_reg;
    level[sxe_pkg::CH_RED]   = (mode_reg == sxe_pkg::MODE_FULL ||
                                mode_reg == sxe_pkg::MODE_RED)   ? px.red   : 8'd0;
    level[sxe_pkg::CH_GREEN] = (mode_reg == sxe_pkg::MODE_FULL ||
                                mode_reg == sxe_pkg::MODE_GREEN) ? px.green : 8'd0;
    level[sxe_pkg::CH_BLUE]  = (mode_reg == sxe_pkg::MODE_FULL ||
                                mode_reg == sxe_pkg::MODE_BLUE)  ? px.blue  : 8'd0;
    // frame header on the first pixel
    if (column_pos == 0 && row_pos == 0) begin
      run_bytes = {sxe_pkg::CHAR_ESC, sxe_pkg::CHAR_P, sxe_pkg::CHAR_Q};
    end
    run_bytes.push_back(sxe_pkg::CHAR_HASH);
    run_bytes.push_back(sxe_pkg::CHAR_ZERO);
    run_bytes.push_back(sxe_pkg::CHAR_SEMI);
    run_bytes.push_back(sxe_pkg::CHAR_TWO);
    // percentages in decimal, no leading zeros
    for (int i = 0; i < sxe_pkg::NUM_CH; i++) begin
      pct = int'(level[i]) * sxe_pkg::PCT_FULL / 255;
      run_bytes.push_back(sxe_pkg::CHAR_SEMI);
      if (pct >= 100) begin
        run_bytes.push_back(8'(sxe_pkg::CHAR_ZERO + pct / 100));
      end
      if (pct >= 10) begin
        run_bytes.push_back(8'(sxe_pkg::CHAR_ZERO + (pct / 10) % 10));
      end
      run_bytes.push_back(8'(sxe_pkg::CHAR_ZERO + pct % 10));
    end
    run_bytes.push_back(sxe_pkg::SIXEL_BIAS + (8'd1 << band_pos));
    // row end and frame trailer
    if (32'(column_pos) + 1 >= w) begin
      run_bytes.push_back((band_pos == sxe_pkg::PHASE_LAST) ? sxe_pkg::CHAR_MINUS
                                                            : sxe_pkg::CHAR_DOLLAR);
      row_ends++;
      column_pos = '0;
      if (32'(row_pos) + 1 >= h) begin
        run_bytes.push_back(sxe_pkg::CHAR_ESC);
        run_bytes.push_back(sxe_pkg::CHAR_BSLASH);
        run_bytes.push_back(sxe_pkg::CHAR_NL);
        frames_closed++;
        row_pos  = '0;
        band_pos = '0;
      end else begin
        row_pos  = row_pos + 12'd1;
        band_pos = (band_pos == sxe_pkg::PHASE_LAST) ? 3'd0 : band_pos + 3'd1;
      end
    end else begin
      column_pos = column_pos + 12'd1;
    end
    foreach (run_bytes[k]) begin
      item_word.out_byte    = run_bytes[k];
      item_word.last_of_run = (k == run_bytes.size() - 1);
      expected_bytes.push_back(item_word);
    end
  endtask

  // pixel word driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_data_q  <= '0;
      in_gap = 0;
    end else begin
      if (in_valid_q && !in_stall_o) begin
        predict_pixel(in_data_q);
        pixels_accepted++;
      end
      if (!in_valid_q || !in_stall_o) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid_q <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 11);
          in_valid_q <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          in_valid_q <= 1'b1;
          in_data_q  <= pending_pixels.pop_front();
        end else begin
          in_valid_q <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started once on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= LONG_HOLD;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output word monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_q <= 1'b0;
      out_burst = 0;
    end else begin
      if (out_valid_o && !out_stall_q) begin
        if (expected_bytes.size() == 0) begin
          flag_error($sformatf("unexpected word byte %h last %b",
                               out_data_o.out_byte, out_data_o.last_of_run));
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_data_o.out_byte !== want.out_byte ||
              out_data_o.last_of_run !== want.last_of_run) begin
            flag_error($sformatf("word %0d: expected byte %h last %b, got byte %h last %b",
                                 bytes_checked, want.out_byte, want.last_of_run,
                                 out_data_o.out_byte, out_data_o.last_of_run));
          end
        end
      end
      if (out_burst != 0) begin
        out_burst--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_burst = $urandom_range(1, 12);
      end
      out_stall_q <= (hold_left != 0) || (out_burst != 0);
    end
  end

  function automatic void queue_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    sxe_pkg::sxe_pixel_t px;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    pending_pixels.push_back(px);
  endfunction

  // levels biased towards the digit-count boundaries
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(0, 3));
      3:       return 8'($urandom_range(23, 28));
      4:       return 8'($urandom_range(250, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [sxe_pkg::CFG_SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 13'd1;
      7:       return 13'($urandom_range(7, 20));
      8:       return 13'($urandom_range(4095, 8191));
      default: return 13'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic void queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      queue_pixel(pick_level(), pick_level(), pick_level());
    end
  endfunction

  task automatic write_reg(input logic [1:0] index,
                           input logic [sxe_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (index)
      sxe_pkg::CFG_IMAGE_WIDTH:  width_reg  = value;
      sxe_pkg::CFG_IMAGE_HEIGHT: height_reg = value;
      sxe_pkg::CFG_CHANNEL_MODE: mode_reg   = value[1:0];
      default: ;
    endcase
  endtask

  // block drained: nothing queued, offered or outstanding, looked at once
  // the edge has settled
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || in_valid_q || expected_bytes.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // stimulus sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset sizes: every pixel is a whole frame, levels at the digit boundaries
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd3, 8'd26, 8'd128);
    wait_idle();

    // two columns by seven rows: every band phase, band end and frame end
    write_reg(sxe_pkg::CFG_IMAGE_WIDTH, 13'd2);
    write_reg(sxe_pkg::CFG_IMAGE_HEIGHT, 13'd7);
    for (int i = 0; i < 14; i++) begin
      queue_pixel(8'(i * 18), 8'(255 - i * 18), 8'(i * 9 + 25));
    end
    wait_idle();

    // zero sizes act as one, single-channel modes
    write_reg(sxe_pkg::CFG_IMAGE_WIDTH, '0);
    write_reg(sxe_pkg::CFG_IMAGE_HEIGHT, '0);
    write_reg(sxe_pkg::CFG_CHANNEL_MODE, sxe_pkg::CFG_DATA_W'(sxe_pkg::MODE_RED));
    queue_pixel(8'd200, 8'd100, 8'd50);
    wait_idle();
    write_reg(sxe_pkg::CFG_CHANNEL_MODE, sxe_pkg::CFG_DATA_W'(sxe_pkg::MODE_GREEN));
    queue_pixel(8'd200, 8'd100, 8'd50);
    wait_idle();
    write_reg(sxe_pkg::CFG_CHANNEL_MODE, sxe_pkg::CFG_DATA_W'(sxe_pkg::MODE_BLUE));
    queue_pixel(8'd200, 8'd100, 8'd50);
    wait_idle();

    // oversized frame, then shrink the width under the current column
    write_reg(sxe_pkg::CFG_CHANNEL_MODE, sxe_pkg::CFG_DATA_W'(sxe_pkg::MODE_FULL));
    write_reg(sxe_pkg::CFG_IMAGE_WIDTH, 13'd8191);
    write_reg(sxe_pkg::CFG_IMAGE_HEIGHT, 13'd8191);
    queue_random(6);
    wait_idle();
    write_reg(sxe_pkg::CFG_IMAGE_WIDTH, 13'd4096);
    queue_random(4);
    wait_idle();
    write_reg(sxe_pkg::CFG_IMAGE_WIDTH, 13'd3);
    write_reg(sxe_pkg::CFG_IMAGE_HEIGHT, 13'd2);
    queue_random(5);
    wait_idle();

    // tall frame, then shrink the height under the current row
    write_reg(sxe_pkg::CFG_IMAGE_WIDTH, 13'd1);
    write_reg(sxe_pkg::CFG_IMAGE_HEIGHT, 13'd4096);
    queue_random(9);
    wait_idle();
    write_reg(sxe_pkg::CFG_IMAGE_HEIGHT, 13'd3);
    queue_random(4);
    wait_idle();

    // receiver holds off while the sender keeps offering
    write_reg(sxe_pkg::CFG_IMAGE_WIDTH, 13'd4);
    write_reg(sxe_pkg::CFG_IMAGE_HEIGHT, 13'd3);
    @(posedge clk_i);
    hold_arm <= 1'b1;
    queue_random(12);
    wait_idle();

    // random settings, mostly whole frames of random pixels
    while (random_items < 120) begin
      if ($urandom_range(0, 2) != 0) write_reg(sxe_pkg::CFG_IMAGE_WIDTH, pick_size());
      if ($urandom_range(0, 2) != 0) write_reg(sxe_pkg::CFG_IMAGE_HEIGHT, pick_size());
      if ($urandom_range(0, 2) != 0) begin
        write_reg(sxe_pkg::CFG_CHANNEL_MODE, 13'($urandom_range(0, 3)));
      end
      if (width_reg <= 36 && height_reg <= 36 &&
          int'(width_reg == 0 ? 1 : width_reg) * int'(height_reg == 0 ? 1 : height_reg) <= 36)
      begin
        burst_len = int'(width_reg == 0 ? 1 : width_reg) *
                    int'(height_reg == 0 ? 1 : height_reg);
      end else begin
        burst_len = $urandom_range(3, 24);
      end
      queue_random(burst_len);
      random_items += burst_len;
      wait_idle();
    end

    // closing stretch at full rate
    @(posedge clk_i);
    quiet <= 1'b1;
    write_reg(sxe_pkg::CFG_IMAGE_WIDTH, 13'd5);
    write_reg(sxe_pkg::CFG_IMAGE_HEIGHT, 13'd6);
    queue_random(30);
    wait_idle();
    repeat (40) @(posedge clk_i);

    if (expected_bytes.size() != 0) begin
      flag_error($sformatf("%0d expected words never arrived", expected_bytes.size()));
    end
    $display("run covered %0d pixels, %0d stream bytes, %0d row ends, %0d closed frames",
             pixels_accepted, bytes_checked, row_ends, frames_closed);
    $display("all channel modes, zero and oversized frames, shrink in mid frame; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
